// ===== hw/rtl/tape_block_loader_deframer_defines.svh =====
// Assertion macros for the tape block loader deframer.
// Bodies refer to the enclosing module's clock and reset ports.
`ifndef TAPE_BLOCK_LOADER_DEFRAMER_DEFINES_SVH
`define TAPE_BLOCK_LOADER_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define TBLD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TBLD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tbld_pkg.sv =====
// Types and constants for the tape block loader deframer.
// No dependencies.
package tbld_pkg;

   localparam int MEM_BYTES = 65536;
   // one above the highest legal end of a block
   localparam logic [17:0] MEM_LIMIT = 18'(MEM_BYTES);
   localparam logic [15:0] SHORT_BLOCK_LEN = 16'd6;
   localparam logic [7:0]  BYTE_BLANK  = 8'h00;
   localparam logic [7:0]  BYTE_MARKER = 8'h01;
   localparam logic [16:0] LENGTH_RESET = 17'h10000;

   typedef enum logic [2:0] {
      PH_SEEK, PH_SKIP, PH_LEN_LO, PH_LEN_HI, PH_ADR_LO, PH_ADR_HI, PH_CSUM, PH_DATA
   } phase_type;

   typedef enum logic [2:0] {
      KIND_WRITE     = 3'd0,
      KIND_BAD_BYTE  = 3'd1,
      KIND_DROPPED   = 3'd2,
      KIND_SHORT_HDR = 3'd3,
      KIND_PAST_END  = 3'd4,
      KIND_DONE      = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [7:0]  write_byte;
      logic [15:0] block_total;
      logic [16:0] byte_total;
   } rsp_type;

   // results caused by one tape byte
   typedef struct packed {
      rsp_type first;
      rsp_type second;
      logic    two;
   } pair_type;

   function automatic rsp_type make_rsp(kind_type kind, logic [15:0] address,
                                        logic [7:0] wbyte, logic [15:0] btot,
                                        logic [16:0] bytot);
      rsp_type r;
      r.kind        = kind;
      r.address     = address;
      r.write_byte  = wbyte;
      r.block_total = btot;
      r.byte_total  = bytot;
      return r;
   endfunction

endpackage

// ===== hw/rtl/tape_block_loader_deframer.sv =====
// Tape block loader deframer: absolute-loader tape bytes in, memory writes,
// warnings and a done report out. Uses tbld_pkg and the defines header.
//
//   channel  dir  transaction
//   req_*    in   one tape byte
//   rsp_*    out  one result (write, warning, error or done)
//   csr_*    in   image length write
//
// A byte is decoded in the cycle it is accepted; its one or two results share
// one entry of a two-entry result queue and leave, while rsp_tready is high,
// one per cycle from the next cycle. Sustained rate is then one byte per cycle
// if no byte gives two results; a byte with two results holds its entry until
// both leave. req_tready is low while both queue entries are occupied. Reset
// (synchronous) returns to marker search with image length 65536.
`include "tape_block_loader_deframer_defines.svh"

module tape_block_loader_deframer
   import tbld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] tape_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [15:0] address, [23:16] write_byte,
                                    // [39:24] block_total, [56:40] byte_total
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data
);

   phase_type   phase_ff, phase_in;
   logic [16:0] len_ff, len_in;
   logic [16:0] pos_ff, pos_in;
   logic [15:0] hdr_len_ff, hdr_len_in;
   logic [15:0] blk_adr_ff, blk_adr_in;
   logic [15:0] remain_ff, remain_in;
   logic [15:0] wptr_ff, wptr_in;
   logic        drop_ff, drop_in;
   logic [15:0] blocks_ff, blocks_in;
   logic [16:0] bytes_ff, bytes_in;
   logic        fin_ff, fin_in;

   pair_type    queue_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff, sel_ff;
   logic [1:0]  count_ff;

   logic        accept, push, pop;
   rsp_type     res [2];
   logic [1:0]  n_res;
   logic [15:0] full_adr, payload_len;
   logic [17:0] block_sum;
   logic [17:0] loaded_sum;
   pair_type    head;
   rsp_type     out_rsp;

   assign accept    = req_tvalid && req_tready;
   assign req_tready = (count_ff != 2'd2);
   assign csr_ready = 1'b1;
   assign len_in    = (csr_valid && csr_ready) ? csr_data : len_ff;

   assign full_adr  = {req_tdata, blk_adr_ff[7:0]};
   assign payload_len = hdr_len_ff - SHORT_BLOCK_LEN;
   assign block_sum = {2'b00, full_adr} + {2'b00, payload_len};
   assign loaded_sum = {1'b0, bytes_ff} + {2'b00, payload_len};

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      hdr_len_in = hdr_len_ff;
      blk_adr_in = blk_adr_ff;
      remain_in  = remain_ff;
      wptr_in    = wptr_ff;
      drop_in    = drop_ff;
      blocks_in  = blocks_ff;
      bytes_in   = bytes_ff;
      fin_in     = fin_ff;
      n_res      = 2'd0;
      res[0]     = make_rsp(KIND_DONE, 16'd0, 8'd0, 16'd0, 17'd0);
      res[1]     = res[0];
      if (!fin_ff) begin
         if (pos_ff >= len_ff) begin
            res[0] = make_rsp(KIND_DONE, 16'd0, 8'd0, blocks_ff, bytes_ff);
            n_res  = 2'd1;
            fin_in = 1'b1;
         end else begin
            case (phase_ff)
               PH_SEEK: begin
                  if (req_tdata == BYTE_MARKER) begin
                     if ({1'b0, pos_ff} + 18'd6 > {1'b0, len_ff}) begin
                        res[0] = make_rsp(KIND_SHORT_HDR, pos_ff[15:0], 8'd0, 16'd0, 17'd0);
                        res[1] = make_rsp(KIND_DONE, 16'd0, 8'd0, blocks_ff, bytes_ff);
                        n_res  = 2'd2;
                        fin_in = 1'b1;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end else if (req_tdata != BYTE_BLANK) begin
                     res[0] = make_rsp(KIND_BAD_BYTE, pos_ff[15:0], 8'd0, 16'd0, 17'd0);
                     n_res  = 2'd1;
                  end
               end
               PH_SKIP: phase_in = PH_LEN_LO;
               PH_LEN_LO: begin
                  hdr_len_in = {8'd0, req_tdata};
                  phase_in   = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  hdr_len_in = {req_tdata, hdr_len_ff[7:0]};
                  phase_in   = PH_ADR_LO;
               end
               PH_ADR_LO: begin
                  blk_adr_in = {8'd0, req_tdata};
                  phase_in   = PH_ADR_HI;
               end
               PH_ADR_HI: begin
                  blk_adr_in = full_adr;
                  if (hdr_len_ff <= SHORT_BLOCK_LEN) begin
                     // start block
                     res[0] = make_rsp(KIND_DONE, full_adr, 8'd0, blocks_ff, bytes_ff);
                     n_res  = 2'd1;
                     fin_in = 1'b1;
                  end else if ({1'b0, pos_ff} + 18'd2 + {2'b00, payload_len}
                               > {1'b0, len_ff}) begin
                     res[0] = make_rsp(KIND_PAST_END, full_adr, 8'd0, 16'd0, 17'd0);
                     res[1] = make_rsp(KIND_DONE, 16'd0, 8'd0, blocks_ff, bytes_ff);
                     n_res  = 2'd2;
                     fin_in = 1'b1;
                  end else begin
                     drop_in = (block_sum > MEM_LIMIT);
                     if (block_sum > MEM_LIMIT) begin
                        res[0] = make_rsp(KIND_DROPPED, full_adr, 8'd0, 16'd0, 17'd0);
                        n_res  = 2'd1;
                     end else begin
                        if (blocks_ff != 16'hFFFF) blocks_in = blocks_ff + 16'd1;
                        bytes_in = loaded_sum[17] ? 17'h1FFFF : loaded_sum[16:0];
                     end
                     wptr_in   = full_adr;
                     remain_in = payload_len;
                     phase_in  = PH_CSUM;
                  end
               end
               PH_CSUM: phase_in = PH_DATA;
               PH_DATA: begin
                  if (!drop_ff) begin
                     res[0] = make_rsp(KIND_WRITE, wptr_ff, req_tdata, 16'd0, 17'd0);
                     n_res  = 2'd1;
                  end
                  wptr_in = wptr_ff + 16'd1;
                  if (remain_ff != 16'd0) remain_in = remain_ff - 16'd1;
                  if (remain_ff <= 16'd1) phase_in = PH_SEEK;
               end
               default: phase_in = PH_SEEK;
            endcase
            pos_in = pos_ff + 17'd1;
            // image end reached by this byte
            if (!fin_in && pos_in >= len_ff) begin
               res[n_res[0]] = make_rsp(KIND_DONE, 16'd0, 8'd0, blocks_in, bytes_in);
               n_res         = n_res + 2'd1;
               fin_in        = 1'b1;
            end
         end
      end
   end

   assign push    = accept && (n_res != 2'd0);
   assign head    = queue_ff[rd_ptr_ff];
   assign out_rsp = sel_ff ? head.second : head.first;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tlast  = sel_ff || !head.two;
   assign pop     = rsp_tvalid && rsp_tready && rsp_tlast;
   assign rsp_tuser = out_rsp.kind;
   assign rsp_tdata = {7'd0, out_rsp.byte_total, out_rsp.block_total,
                       out_rsp.write_byte, out_rsp.address};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEEK;
         len_ff    <= LENGTH_RESET;
         pos_ff    <= 17'd0;
         hdr_len_ff <= 16'd0;
         blk_adr_ff <= 16'd0;
         remain_ff <= 16'd0;
         wptr_ff   <= 16'd0;
         drop_ff   <= 1'b0;
         blocks_ff <= 16'd0;
         bytes_ff  <= 17'd0;
         fin_ff    <= 1'b0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         sel_ff    <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         len_ff <= len_in;
         if (accept) begin
            phase_ff   <= phase_in;
            pos_ff     <= pos_in;
            hdr_len_ff <= hdr_len_in;
            blk_adr_ff <= blk_adr_in;
            remain_ff  <= remain_in;
            wptr_ff    <= wptr_in;
            drop_ff    <= drop_in;
            blocks_ff  <= blocks_in;
            bytes_ff   <= bytes_in;
            fin_ff     <= fin_in;
         end
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
            sel_ff    <= 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            sel_ff <= 1'b1;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{first: res[0], second: res[1], two: n_res[1]};
      end
   end

   `TBLD_ASSERT_NOW(a_count_range, 1'b1, count_ff <= 2'd2, "result queue overflow")
   `TBLD_ASSERT_NOW(a_quiet_after_done, accept && fin_ff, !push,
                    "result after load finished")
   `TBLD_ASSERT_NOW(a_done_is_last, rsp_tvalid && rsp_tuser == KIND_DONE, rsp_tlast,
                    "done result not last of its byte")
   `TBLD_ASSERT_NEXT(a_done_sets_fin,
                     push && (res[0].kind == KIND_DONE ||
                              (n_res[1] && res[1].kind == KIND_DONE)),
                     fin_ff, "done pushed without finishing")

endmodule
